// ===== design/pee_pkg.sv =====
`default_nettype none

package pee_pkg;

  // ASCII codes of the expression alphabet
  localparam logic [7:0] SYM_ZERO  = 8'h30;
  localparam logic [7:0] SYM_NINE  = 8'h39;
  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_TIMES = 8'h2A;
  localparam logic [7:0] SYM_DIV   = 8'h2F;
  localparam logic [7:0] SYM_SPACE = 8'h20;

  // Iterations of the shift-add multiply and restoring divide
  localparam int unsigned ALU_STEPS = 8;
  localparam int unsigned ALU_CNT_W = $clog2(ALU_STEPS + 1);

  typedef enum logic [2:0] {
    ST_RESULT  = 3'd0,
    ST_DRAIN   = 3'd1,
    ST_FULL    = 3'd2,
    ST_UNDER   = 3'd3,
    ST_DIVZERO = 3'd4,
    ST_UNKNOWN = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic       start;
    alu_op_t    op;
    logic [7:0] lhs;
    logic [7:0] rhs;
  } alu_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] result;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_A,
    S_POP_B,
    S_EXEC,
    S_EMIT,
    S_CHECK,
    S_DRAIN_RD,
    S_DRAIN_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== design/pee_in_if.sv =====
`default_nettype none

interface pee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_expression;

  modport source (output valid, output symbol, output end_of_expression, input ready);
  modport sink   (input valid, input symbol, input end_of_expression, output ready);
endinterface

`default_nettype wire

// ===== design/pee_out_if.sv =====
`default_nettype none

interface pee_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] value;
  logic [2:0]        status;
  logic              last_of_run;

  modport source (output valid, output value, output status, output last_of_run, input ready);
  modport sink   (input valid, input value, input status, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== design/pee_alu.sv =====
`default_nettype none

module pee_alu (
  input  wire               clk,
  input  wire               rst_n,
  input  pee_pkg::alu_req_t req,
  output pee_pkg::alu_rsp_t rsp
);
  import pee_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [7:0]           res_r, res_nxt;
  logic                 is_div_r, is_div_nxt;
  logic                 neg_r, neg_nxt;
  logic [ALU_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [8:0]           acc_r, acc_nxt;
  logic [7:0]           x_r, x_nxt;
  logic [7:0]           y_r, y_nxt;
  logic [8:0]           shifted;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    res_r    <= res_nxt;
    is_div_r <= is_div_nxt;
    neg_r    <= neg_nxt;
    cnt_r    <= cnt_nxt;
    acc_r    <= acc_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
  end

  // Add and subtract register their result directly; multiply and divide load operands, then advance one bit per cycle
  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    res_nxt    = res_r;
    is_div_nxt = is_div_r;
    neg_nxt    = neg_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    shifted    = {acc_r[7:0], x_r[7]};

    if (req.start) begin
      case (req.op)
        ALU_ADD: begin
          res_nxt  = req.lhs + req.rhs;
          done_nxt = 1'b1;
        end
        ALU_SUB: begin
          res_nxt  = req.lhs - req.rhs;
          done_nxt = 1'b1;
        end
        ALU_MUL: begin
          busy_nxt   = 1'b1;
          is_div_nxt = 1'b0;
          cnt_nxt    = '0;
          acc_nxt    = '0;
          x_nxt      = req.rhs;
          y_nxt      = req.lhs;
        end
        ALU_DIV: begin
          busy_nxt   = 1'b1;
          is_div_nxt = 1'b1;
          cnt_nxt    = '0;
          acc_nxt    = '0;
          neg_nxt    = req.lhs[7] ^ req.rhs[7];
          // magnitudes; 128 fits as unsigned
          x_nxt      = req.lhs[7] ? 8'(-req.lhs) : req.lhs;
          y_nxt      = req.rhs[7] ? 8'(-req.rhs) : req.rhs;
        end
        default: begin
          done_nxt = 1'b0;
        end
      endcase
    end else if (busy_r) begin
      if (cnt_r == ALU_CNT_W'(ALU_STEPS)) begin
        // Finish: product low byte or signed quotient
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (is_div_r) begin
          res_nxt = neg_r ? 8'(-x_r) : x_r;
        end else begin
          res_nxt = acc_r[7:0];
        end
      end else begin
        cnt_nxt = cnt_r + ALU_CNT_W'(1);
        if (is_div_r) begin
          // Restoring divide step: remainder in acc, quotient shifts into x
          x_nxt = {x_r[6:0], 1'b0};
          if (shifted >= {1'b0, y_r}) begin
            acc_nxt  = shifted - {1'b0, y_r};
            x_nxt[0] = 1'b1;
          end else begin
            acc_nxt = shifted;
          end
        end else begin
          // Shift-add step, kept to eight bits
          if (x_r[0]) begin
            acc_nxt = {1'b0, acc_r[7:0] + y_r};
          end
          x_nxt = {1'b0, x_r[7:1]};
          y_nxt = {y_r[6:0], 1'b0};
        end
      end
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

`default_nettype wire

// ===== design/pee_stack.sv =====
`default_nettype none

module pee_stack #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire          clk,
  input  wire          rd_en,
  input  wire [AW-1:0] rd_addr,
  output logic [7:0]   rd_data,
  input  wire          wr_en,
  input  wire [AW-1:0] wr_addr,
  input  wire [7:0]    wr_data
);

  logic [7:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/postfix_expression_evaluator_unit.sv =====
// Channel  Dir  Word                                       Handshake
// in_ch    in   symbol[7:0], end_of_expression             valid/ready
// out_ch   out  value[7:0] signed, status[2:0], last_of_run valid/ready
//
// One character at a time; in_ch.ready is high only while the sequencer idles.
// Digit: push; space: skip. + - * /: two stack pops, the ALU, the push and the
// output load; * and / run the eight iterations of the shared multiply/divide
// unit with its finish step. Full stack, underflow, unknown character and
// divide by zero each send a status word. A drain reads and sends each entry.
// Reset (rst_n low, synchronous) empties the stack count; entries are not cleared.
// A stalled out_ch holds the result register; the next character is taken
// while the last word of a run still waits there.
`default_nettype none

module postfix_expression_evaluator_unit #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input wire        clk,
  input wire        rst_n,
  pee_in_if.sink    in_ch,
  pee_out_if.source out_ch
);
  import pee_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [7:0]      sym_r, sym_nxt;
  logic            last_r, last_nxt;
  logic [7:0]      a_r, a_nxt;
  logic [7:0]      pend_val_r, pend_val_nxt;
  status_t         pend_st_r, pend_st_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_value_r, out_value_nxt;
  status_t         out_status_r, out_status_nxt;
  logic            out_last_r, out_last_nxt;

  logic            slot_free;
  logic [CW-1:0]   count_dec;
  logic            is_digit, is_op, drain_more;
  alu_op_t         op_sel;
  alu_req_t        alu_req;
  alu_rsp_t        alu_rsp;
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [7:0]      rd_data, wr_data;

  pee_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  pee_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sym_r        <= sym_nxt;
    last_r       <= last_nxt;
    a_r          <= a_nxt;
    pend_val_r   <= pend_val_nxt;
    pend_st_r    <= pend_st_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign slot_free  = !out_valid_r || out_ch.ready;
  assign count_dec  = count_r - CW'(1);
  assign is_digit   = sym_r inside {[SYM_ZERO:SYM_NINE]};
  assign is_op      = sym_r inside {SYM_PLUS, SYM_MINUS, SYM_TIMES, SYM_DIV};
  assign drain_more = last_r && (count_r != '0);

  // Map the operator character to an ALU operation
  always_comb begin
    case (sym_r)
      SYM_PLUS:  op_sel = ALU_ADD;
      SYM_MINUS: op_sel = ALU_SUB;
      SYM_TIMES: op_sel = ALU_MUL;
      SYM_DIV:   op_sel = ALU_DIV;
      default:   op_sel = ALU_ADD;
    endcase
  end

  // Sequencer: next state, stack accesses, ALU start and output loads
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    sym_nxt        = sym_r;
    last_nxt       = last_r;
    a_nxt          = a_r;
    pend_val_nxt   = pend_val_r;
    pend_st_nxt    = pend_st_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    rd_en          = 1'b0;
    rd_addr        = count_dec[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = count_r[AW-1:0];
    wr_data        = '0;
    alu_req        = '{start: 1'b0, op: op_sel, lhs: rd_data, rhs: a_r};

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          sym_nxt   = in_ch.symbol;
          last_nxt  = in_ch.end_of_expression;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (is_digit) begin
          if (count_r == CW'(STACK_DEPTH)) begin
            pend_val_nxt = '0;
            pend_st_nxt  = ST_FULL;
            state_nxt    = S_EMIT;
          end else begin
            wr_en     = 1'b1;
            wr_data   = sym_r - SYM_ZERO;
            count_nxt = count_r + CW'(1);
            state_nxt = S_CHECK;
          end
        end else if (is_op) begin
          if (count_r < CW'(2)) begin
            // drop whatever operands there are
            count_nxt    = '0;
            pend_val_nxt = '0;
            pend_st_nxt  = ST_UNDER;
            state_nxt    = S_EMIT;
          end else begin
            rd_en     = 1'b1;
            count_nxt = count_dec;
            state_nxt = S_POP_A;
          end
        end else if (sym_r == SYM_SPACE) begin
          state_nxt = S_CHECK;
        end else begin
          pend_val_nxt = '0;
          pend_st_nxt  = ST_UNKNOWN;
          state_nxt    = S_EMIT;
        end
      end
      S_POP_A: begin
        a_nxt     = rd_data;
        rd_en     = 1'b1;
        count_nxt = count_dec;
        state_nxt = S_POP_B;
      end
      S_POP_B: begin
        if (op_sel == ALU_DIV && a_r == '0) begin
          wr_en        = 1'b1;
          wr_data      = '0;
          count_nxt    = count_r + CW'(1);
          pend_val_nxt = '0;
          pend_st_nxt  = ST_DIVZERO;
          state_nxt    = S_EMIT;
        end else begin
          alu_req.start = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (alu_rsp.done) begin
          wr_en        = 1'b1;
          wr_data      = alu_rsp.result;
          count_nxt    = count_r + CW'(1);
          pend_val_nxt = alu_rsp.result;
          pend_st_nxt  = ST_RESULT;
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = pend_val_r;
          out_status_nxt = pend_st_r;
          out_last_nxt   = !drain_more;
          state_nxt      = drain_more ? S_DRAIN_RD : S_IDLE;
        end
      end
      S_CHECK: begin
        state_nxt = drain_more ? S_DRAIN_RD : S_IDLE;
      end
      S_DRAIN_RD: begin
        rd_en     = 1'b1;
        count_nxt = count_dec;
        state_nxt = S_DRAIN_OUT;
      end
      S_DRAIN_OUT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = rd_data;
          out_status_nxt = ST_DRAIN;
          out_last_nxt   = (count_r == '0);
          state_nxt      = (count_r == '0) ? S_IDLE : S_DRAIN_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.value       = out_value_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.last_of_run = out_last_r;

  // Stack count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // ALU answers only while the sequencer waits for it
  a_alu_done_exec: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> state_r == S_EXEC)
    else $error("ALU result outside execute state");

  // An accepted character goes straight to decode
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> state_r == S_DISPATCH)
    else $error("accepted character not dispatched");

  // A drained word leaves the stack one entry smaller
  a_drain_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN_RD |=> count_r == $past(count_r) - CW'(1))
    else $error("drain read did not pop");

endmodule

`default_nettype wire

// ===== test/postfix_expression_evaluator_unit_tb.sv =====
`timescale 1ns / 1ps

module postfix_expression_evaluator_unit_tb;
  import pee_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned RANDOM_ITEMS = 170;
  localparam int unsigned IDLE_PCT = 34;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 60;

  typedef struct {
    logic signed [7:0] value;
    status_t           status;
    logic              last_of_run;
  } result_word_t;

  logic clk = 1'b0;
  logic rst_n;
  bit calm = 1'b0;
  int errors = 0;
  int quiet_cycles = 0;

  // Expected result words, oldest first, and the shadow stack
  result_word_t pending_results[$];
  logic [7:0] stack_mem[DEPTH];
  int unsigned stack_fill = 0;

  pee_in_if in_ch();
  pee_out_if out_ch();

  postfix_expression_evaluator_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Evaluate one accepted character and queue the words it causes
  function automatic void evaluate_symbol(input logic [7:0] sym, input logic eoe);
    result_word_t batch[$];
    int lhs;
    int rhs;
    int res;
    if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
      if (stack_fill >= DEPTH) begin
        batch.push_back('{8'sd0, ST_FULL, 1'b0});
      end else begin
        stack_mem[stack_fill] = sym - SYM_ZERO;
        stack_fill++;
      end
    end else if (sym == SYM_PLUS || sym == SYM_MINUS || sym == SYM_TIMES || sym == SYM_DIV) begin
      if (stack_fill < 2) begin
        // discard whatever operand is there
        stack_fill = 0;
        batch.push_back('{8'sd0, ST_UNDER, 1'b0});
      end else begin
        rhs = $signed(stack_mem[stack_fill - 1]);
        lhs = $signed(stack_mem[stack_fill - 2]);
        stack_fill -= 2;
        if (sym == SYM_DIV && rhs == 0) begin
          stack_mem[stack_fill] = 8'd0;
          stack_fill++;
          batch.push_back('{8'sd0, ST_DIVZERO, 1'b0});
        end else begin
          case (sym)
            SYM_PLUS:  res = lhs + rhs;
            SYM_MINUS: res = lhs - rhs;
            SYM_TIMES: res = lhs * rhs;
            default:   res = lhs / rhs;
          endcase
          // wrap to 8 bits; -128 / -1 lands back on -128
          stack_mem[stack_fill] = res[7:0];
          stack_fill++;
          batch.push_back('{res[7:0], ST_RESULT, 1'b0});
        end
      end
    end else if (sym != SYM_SPACE) begin
      batch.push_back('{8'sd0, ST_UNKNOWN, 1'b0});
    end

    // Drain top first after the character itself
    if (eoe) begin
      while (stack_fill > 0) begin
        stack_fill--;
        batch.push_back('{stack_mem[stack_fill], ST_DRAIN, 1'b0});
      end
    end

    if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
    foreach (batch[i]) pending_results.push_back(batch[i]);
  endfunction

  // Check each result word, then predict from each accepted input word
  always @(posedge clk) begin
    result_word_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected word value %0d status %0d last %0b",
                                    out_ch.value, out_ch.status, out_ch.last_of_run));
        end else begin
          want = pending_results.pop_front();
          if (out_ch.value !== want.value)
            report_mismatch($sformatf("value %0d, want %0d", out_ch.value, want.value));
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("status %0d, want %s", out_ch.status, want.status.name()));
          if (out_ch.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %0b, want %0b",
                                      out_ch.last_of_run, want.last_of_run));
        end
      end
      if (in_ch.valid && in_ch.ready) evaluate_symbol(in_ch.symbol, in_ch.end_of_expression);
    end
  end

  // Stall the result channel at random, except in the calm stretch
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // End the run when no word moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("postfix_expression_evaluator_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one word, with an optional idle gap ahead of it
  task automatic send_symbol(input logic [7:0] sym, input logic eoe);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.symbol <= sym;
    in_ch.end_of_expression <= eoe;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
  endtask

  task automatic send_text(input string text, input bit close);
    for (int i = 0; i < text.len(); i++) send_symbol(text[i], close && i == text.len() - 1);
  endtask

  function automatic logic [7:0] random_operator();
    case ($urandom_range(3))
      0: return SYM_PLUS;
      1: return SYM_MINUS;
      2: return SYM_TIMES;
      default: return SYM_DIV;
    endcase
  endfunction

  // All four operators, wrap on multiply, -128 / -1, truncation toward zero
  task automatic test_arithmetic();
    send_text("88*2*01-/3/5+", 1'b0);
  endtask

  // Divide by zero, unknown characters, drain, underflow, empty drain
  task automatic test_error_cases();
    send_text("50/", 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(SYM_SPACE, 1'b1);
    send_text("7-", 1'b1);
    send_symbol(SYM_TIMES, 1'b0);
    send_symbol(8'h00, 1'b0);
  endtask

  // Fill the stack, push once more, drain all sixteen entries
  task automatic test_stack_limits();
    for (int i = 0; i < DEPTH + 1; i++) send_symbol(SYM_ZERO + 8'(i % 10), i == DEPTH);
  endtask

  // Mostly well-formed expressions with random digits; some noise and broken input
  task automatic test_random_expressions();
    logic [8:0] words[$];
    logic [7:0] digit;
    int sent;
    int kind;
    int operands;
    int pushed;
    int depth;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent >= 90 && sent < 140);
      words.delete();
      kind = $urandom_range(99);
      if (kind < 10) begin
        // any byte, end mark at random
        repeat ($urandom_range(1, 4))
          words.push_back({1'($urandom_range(1)), 8'($urandom_range(255))});
      end else if (kind < 14) begin
        // flood the stack toward full
        repeat ($urandom_range(10, 18)) begin
          digit = SYM_ZERO + 8'($urandom_range(9));
          words.push_back({1'b0, digit});
        end
      end else if (kind < 20) begin
        // operator with whatever is on the stack
        words.push_back({1'($urandom_range(1)), random_operator()});
      end else begin
        operands = $urandom_range(1, 7);
        pushed = 0;
        depth = 0;
        while (pushed < operands || depth > 1) begin
          if (pushed < operands && (depth < 2 || $urandom_range(1) == 1)) begin
            digit = SYM_ZERO + 8'($urandom_range(9));
            words.push_back({1'b0, digit});
            pushed++;
            depth++;
          end else begin
            words.push_back({1'b0, random_operator()});
            depth--;
          end
          if ($urandom_range(9) == 0) words.push_back({1'b0, SYM_SPACE});
        end
        // close on a space, on the last character, or leave the stack loaded
        case ($urandom_range(3))
          0: words.push_back({1'b1, SYM_SPACE});
          1: ;
          default: words[words.size() - 1][8] = 1'b1;
        endcase
      end
      foreach (words[i]) begin
        send_symbol(words[i][7:0], words[i][8]);
        if (words[i][7:0] != SYM_SPACE) sent++;
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.symbol <= 8'd0;
    in_ch.end_of_expression <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_arithmetic();
    test_error_cases();
    test_stack_limits();
    test_random_expressions();
    in_ch.valid <= 1'b0;

    // Wait out the remaining words, then give the block time to misbehave
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("postfix_expression_evaluator_unit verification clean");
    end else begin
      $display("postfix_expression_evaluator_unit verification failed");
    end
    $finish;
  end

endmodule
